>>> src/sobel_pkg.sv
package sobel_pkg;

  // Pixel and channel types; channel 0 is red, 1 green, 2 blue
  typedef logic [7:0]      chan_t;
  typedef chan_t [2:0]     pixel_t;

  // One line-store entry: the row two back and the row one back
  typedef struct packed {
    pixel_t upper;
    pixel_t mid;
  } line_pair_t;

  // Signed gradient sum of one channel, range -1020..1020
  typedef logic signed [10:0] grad_t;

  // Output coordinate fields
  localparam int OUT_COL_W = 11;
  localparam int OUT_ROW_W = 12;
  typedef logic [OUT_COL_W-1:0] ocol_t;
  typedef logic [OUT_ROW_W-1:0] orow_t;

  // Size registers
  localparam int FW_W = 12;
  localparam int FH_W = 13;
  typedef logic [FW_W-1:0] fwidth_t;
  typedef logic [FH_W-1:0] fheight_t;
  localparam int CFG_DATA_W = 13;
  localparam int MIN_FRAME  = 3;

  // Register indexes on the config port
  localparam int CFG_ADDR_W = 2;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_addr_t REG_FRAME_HEIGHT = 2'd1;

  localparam chan_t EDGE_LIMIT = 8'd255;

endpackage

>>> src/sobel_ram.sv
module sobel_ram import sobel_pkg::*; #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/sobel_rgb_edge_filter.sv
// 3x3 Sobel edge filter on RGB pixels streamed in raster order. Frame size
// comes from two registers (index 0 width, index 1 height, saturated to
// 3..MAX_WIDTH and 3..MAX_HEIGHT); writing either one restarts the frame at
// row 0, column 0. One pixel is taken every clock unless stalled, set by
// the single read-modify-write pass over the line-store RAM per pixel; a
// result passes every stage after the pixel below and to the right of it is
// taken. Each channel gives |Gx|+|Gy| clamped to 255, zero for first-row
// and first-column pixels, tagged with its column and row. Pixels of the
// last row and last column give no result. The line store needs no clearing
// after reset: unwritten entries only feed results that are forced to zero.
module sobel_rgb_edge_filter import sobel_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel_red, pixel_green, pixel_blue
  input  logic [23:0]           in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // edge_red, edge_green, edge_blue, out_column, out_row, 1 pad bit
  output logic [47:0]           out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int FW_RST = (640 > MAX_WIDTH)  ? MAX_WIDTH  : 640;
  localparam int FH_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  fwidth_t  fw_r;
  fheight_t fh_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  // Pipeline stage registers
  logic          s1_v_r, s1_emit_r, s1_zero_r;
  pixel_t        s1_px_r;
  logic [CW-1:0] s1_col_r;
  ocol_t         s1_oc_r;
  orow_t         s1_orow_r;

  logic          s2_v_r, s2_emit_r, s2_zero_r;
  ocol_t         s2_oc_r;
  orow_t         s2_orow_r;
  pixel_t        win_r [9];

  logic          s3_v_r, s3_zero_r;
  ocol_t         s3_oc_r;
  orow_t         s3_orow_r;
  grad_t         gx_r [3];
  grad_t         gy_r [3];

  logic          out_v_r;
  pixel_t        out_edge_r;
  ocol_t         out_oc_r;
  orow_t         out_orow_r;

  logic rdy_o, rdy3, rdy2, rdy1, in_acc, s1_adv;
  line_pair_t ram_q, ram_wd;
  fwidth_t  cfg_fw;
  fheight_t cfg_fh;
  logic     col_last, row_last;

  // Elastic stage handshake: a stage loads when empty or when it drains
  assign rdy_o     = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy_o;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && rdy1;
  assign s1_adv    = s1_v_r && rdy2;

  // Line store: read at accept, write back when the pixel leaves stage 1.
  // Consecutive pixels hit different columns unless a config write restarts the raster; no forwarding is done.
  assign ram_wd.upper = ram_q.mid;
  assign ram_wd.mid   = s1_px_r;

  sobel_ram #(
    .WIDTH ($bits(line_pair_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (ram_wd),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_q)
  );

  // Saturated size values from the config port
  always_comb begin
    cfg_fw = cfg_wdata[FW_W-1:0];
    if (32'(cfg_fw) < MIN_FRAME) begin
      cfg_fw = fwidth_t'(MIN_FRAME);
    end else if (32'(cfg_fw) > MAX_WIDTH) begin
      cfg_fw = fwidth_t'(MAX_WIDTH);
    end
    cfg_fh = cfg_wdata[FH_W-1:0];
    if (32'(cfg_fh) < MIN_FRAME) begin
      cfg_fh = fheight_t'(MIN_FRAME);
    end else if (32'(cfg_fh) > MAX_HEIGHT) begin
      cfg_fh = fheight_t'(MAX_HEIGHT);
    end
  end

  assign col_last = (32'(col_r) + 32'd1) >= 32'(fw_r);
  assign row_last = (32'(row_r) + 32'd1) >= 32'(fh_r);

  // Size registers and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= fwidth_t'(FW_RST);
      fh_r  <= fheight_t'(FH_RST);
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FRAME_WIDTH: begin
          fw_r  <= cfg_fw;
          col_r <= '0;
          row_r <= '0;
        end
        REG_FRAME_HEIGHT: begin
          fh_r  <= cfg_fh;
          col_r <= '0;
          row_r <= '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)  s1_v_r  <= in_tvalid;
      if (rdy2)  s2_v_r  <= s1_v_r;
      if (rdy3)  s3_v_r  <= s2_v_r && s2_emit_r;
      if (rdy_o) out_v_r <= s3_v_r;
    end
  end

  // Stage 1: pixel, address and result coordinates wait for RAM data
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= in_tdata;
      s1_col_r  <= col_r;
      s1_emit_r <= (col_r != '0) && (row_r != '0);
      s1_zero_r <= (col_r == CW'(1)) || (row_r == RW'(1));
      s1_oc_r   <= ocol_t'(col_r - 1'b1);
      s1_orow_r <= orow_t'(row_r - 1'b1);
    end
  end

  // Stage 2: shift the window by one column, newest column on the right
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r[0]  <= win_r[1];
      win_r[1]  <= win_r[2];
      win_r[3]  <= win_r[4];
      win_r[4]  <= win_r[5];
      win_r[6]  <= win_r[7];
      win_r[7]  <= win_r[8];
      win_r[2]  <= ram_q.upper;
      win_r[5]  <= ram_q.mid;
      win_r[8]  <= s1_px_r;
      s2_emit_r <= s1_emit_r;
      s2_zero_r <= s1_zero_r;
      s2_oc_r   <= s1_oc_r;
      s2_orow_r <= s1_orow_r;
    end
  end

  // Stage 3: horizontal and vertical Sobel sums per channel
  always_ff @(posedge clk) begin
    if (s2_v_r && rdy3) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_r[ch] <= $signed({1'b0, {2'b0, win_r[2][ch]} + {1'b0, win_r[5][ch], 1'b0}
                                 + {2'b0, win_r[8][ch]}})
                  - $signed({1'b0, {2'b0, win_r[0][ch]} + {1'b0, win_r[3][ch], 1'b0}
                                 + {2'b0, win_r[6][ch]}});
        gy_r[ch] <= $signed({1'b0, {2'b0, win_r[6][ch]} + {1'b0, win_r[7][ch], 1'b0}
                                 + {2'b0, win_r[8][ch]}})
                  - $signed({1'b0, {2'b0, win_r[0][ch]} + {1'b0, win_r[1][ch], 1'b0}
                                 + {2'b0, win_r[2][ch]}});
      end
      s3_zero_r <= s2_zero_r;
      s3_oc_r   <= s2_oc_r;
      s3_orow_r <= s2_orow_r;
    end
  end

  // Output stage: magnitude, clamp and border zero
  grad_t       ax [3];
  grad_t       ay [3];
  logic [10:0] mag [3];
  pixel_t      edge_nxt;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      ax[ch]  = gx_r[ch][10] ? -gx_r[ch] : gx_r[ch];
      ay[ch]  = gy_r[ch][10] ? -gy_r[ch] : gy_r[ch];
      mag[ch] = {1'b0, ax[ch][9:0]} + {1'b0, ay[ch][9:0]};
      if (s3_zero_r) begin
        edge_nxt[ch] = '0;
      end else if (mag[ch] > 11'(EDGE_LIMIT)) begin
        edge_nxt[ch] = EDGE_LIMIT;
      end else begin
        edge_nxt[ch] = mag[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && rdy_o) begin
      out_edge_r <= edge_nxt;
      out_oc_r   <= s3_oc_r;
      out_orow_r <= s3_orow_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_orow_r, out_oc_r, out_edge_r};

endmodule
